>>> rtl/core/month_filtered_sum_unit_defines.svh
// Assertion macros shared by the month_filtered_sum_unit RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef MONTH_FILTERED_SUM_UNIT_DEFINES_SVH
`define MONTH_FILTERED_SUM_UNIT_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define MFS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication: when pre holds, post holds at the next edge.
`define MFS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/core/mfs_pkg.sv
// Shared types, constants and calendar tables for month_filtered_sum_unit.
// No dependencies.
`timescale 1ns / 1ps

package mfs_pkg;

  // Record and result widths
  localparam int unsigned TS_W     = 48;
  localparam int unsigned AMOUNT_W = 32;
  localparam int unsigned TOTAL_W  = 64;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_YEAR  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MONTH = 8'd1;
  localparam logic [15:0] YEAR_RESET  = 16'd1970;
  localparam logic [3:0]  MONTH_RESET = 4'd0;

  // Day divider: quotient of a 47-bit timestamp by ms/day fits in 21 bits
  localparam int unsigned DAYS_W      = 21;
  localparam int unsigned REM_W       = 27;
  localparam logic [REM_W-1:0] MS_PER_DAY = 27'd86400000;
  localparam int unsigned DIV_STEPS   = 3;
  localparam int unsigned DIV_CYCLES  = DAYS_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_CYCLES);

  // Calendar window arithmetic
  localparam int unsigned WIN_W       = 26;
  localparam int unsigned Q100_W      = 10;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned PROD_W      = 34;
  localparam logic [17:0] RECIP_100   = 18'd167773;  // ceil(2^24 / 100)
  localparam logic [15:0] BASE_YEAR   = 16'd1970;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [8:0]  LEAPS_BEFORE_BASE = 9'd477;  // leap years in 1..1969
  localparam logic [3:0]  MONTHS      = 4'd12;
  localparam logic [3:0]  MONTH_FEB   = 4'd1;
  localparam logic [3:0]  MONTH_MAR   = 4'd2;
  localparam logic [1:0]  WIN_SETTLE  = 2'd2;

  // Queue between classifier and accumulator
  localparam int unsigned QUEUE_DEPTH = 4;

  // Saturation bounds
  localparam logic [OUT_DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_e;

  // Target month as a half-open day range since 1970-01-01
  typedef struct packed {
    logic             valid;
    logic             ok;
    logic [WIN_W-1:0] lo;
    logic [WIN_W-1:0] hi;
  } win_t;

  typedef struct packed {
    logic                       last;
    logic                       match;
    logic signed [AMOUNT_W-1:0] amount;
  } q_entry_t;

  // Days in a month of a common year
  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd1:                      d = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  // Day of a common year on which a month starts
  function automatic logic [8:0] month_first(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/core/mfs_fifo.sv
// Short queue of classified records between front and back.
// Depends on mfs_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "month_filtered_sum_unit_defines.svh"

module mfs_fifo #(
  parameter int unsigned Depth = mfs_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mfs_pkg::q_entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output mfs_pkg::q_entry_t pop_data_o,
  output logic              empty_o
);
  import mfs_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_entry_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `MFS_ASSERT(a_no_push_full, !(push_i && full_o && !pop_i), "push into full queue")
  `MFS_ASSERT(a_no_pop_empty, !(pop_i && empty_o), "pop from empty queue")
  `MFS_ASSERT_NEXT(a_cnt_track, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1,
                   "queue count lost a push")

endmodule

>>> rtl/core/mfs_window.sv
// Target registers and the day range of the target month they select.
// Depends on mfs_pkg.
`timescale 1ns / 1ps

module mfs_window (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mfs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mfs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output mfs_pkg::win_t                   win_o
);
  import mfs_pkg::*;

  logic [15:0]       year_q;
  logic [3:0]        month_q;
  logic [1:0]        busy_q;

  // stage A: divide year and year-1 by 100 through the reciprocal
  logic [15:0]       year_m1;
  logic [PROD_W-1:0] prod_n, prod_y;
  logic [Q100_W-1:0] qn_q, qy_q;

  // stage B: range of the month
  logic [15:0]       yoff;
  logic [WIN_W-1:0]  days_y, leaps, lo_d, hi_d;
  logic              century, leap, ok_d;
  logic [WIN_W-1:0]  lo_q, hi_q;
  logic              ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q  <= YEAR_RESET;
      month_q <= MONTH_RESET;
      busy_q  <= WIN_SETTLE;
    end else begin
      if (cfg_we_i) begin
        busy_q <= WIN_SETTLE;
        unique case (cfg_idx_i)
          CFG_TARGET_YEAR:  year_q  <= cfg_wdata_i;
          CFG_TARGET_MONTH: month_q <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end else if (busy_q != '0) begin
        busy_q <= busy_q - 1'b1;
      end
    end
  end

  assign year_m1 = year_q - 16'd1;
  assign prod_n  = PROD_W'(year_m1) * PROD_W'(RECIP_100);
  assign prod_y  = PROD_W'(year_q) * PROD_W'(RECIP_100);

  always_ff @(posedge clk_i) begin
    qn_q <= prod_n[RECIP_SHIFT +: Q100_W];
    qy_q <= prod_y[RECIP_SHIFT +: Q100_W];
  end

  always_comb begin
    yoff    = year_q - BASE_YEAR;
    days_y  = WIN_W'(yoff) * WIN_W'(DAYS_PER_YEAR);
    // leap years from 1970 up to the year before the target
    leaps   = WIN_W'(year_m1 >> 2) - WIN_W'(qn_q) + WIN_W'(qn_q >> 2)
            - WIN_W'(LEAPS_BEFORE_BASE);
    century = (16'(qy_q) * 16'd100 == year_q);
    leap    = ((year_q[1:0] == 2'b00) && !century) || (century && (qy_q[1:0] == 2'b00));
    lo_d    = days_y + leaps + WIN_W'(month_first(month_q))
            + WIN_W'(leap && (month_q >= MONTH_MAR));
    hi_d    = lo_d + WIN_W'(month_days(month_q)) + WIN_W'(leap && (month_q == MONTH_FEB));
    // years before 1970 and months past December never match
    ok_d    = (year_q >= BASE_YEAR) && (month_q < MONTHS);
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    ok_q <= ok_d;
  end

  assign win_o.valid = (busy_q == '0);
  assign win_o.ok    = ok_q;
  assign win_o.lo    = lo_q;
  assign win_o.hi    = hi_q;

endmodule

>>> rtl/core/mfs_front.sv
// Front end: accepts records, divides the timestamp into days and
// classifies the record against the target month. Depends on mfs_pkg.
`timescale 1ns / 1ps
`include "month_filtered_sum_unit_defines.svh"

module mfs_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [mfs_pkg::TS_W-1:0]     in_ts_i,
  input  logic signed [mfs_pkg::AMOUNT_W-1:0] in_amount_i,
  input  logic                                in_last_i,
  input  mfs_pkg::win_t                       win_i,
  output logic                                push_o,
  output mfs_pkg::q_entry_t                   push_data_o,
  input  logic                                full_i
);
  import mfs_pkg::*;

  front_state_e                state_q, state_d;
  logic [DIV_CNT_W-1:0]        cnt_q;
  logic [REM_W-1:0]            rem_q, rem_d;
  logic [DAYS_W-1:0]           lo_q, lo_d;
  logic [DAYS_W-1:0]           quo_q, quo_d;
  logic signed [AMOUNT_W-1:0]  amount_q;
  logic                        last_q;
  logic                        accept;
  logic                        div_done;
  logic                        match;
  logic [REM_W:0]              trial;

  assign accept   = in_valid_i && in_ready_o;
  assign div_done = (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FR_IDLE: if (accept) state_d = FR_DIV;
      FR_DIV:  if (div_done) state_d = FR_PUSH;
      FR_PUSH: begin
        if (!full_i) state_d = accept ? FR_DIV : FR_IDLE;
      end
      default: state_d = FR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    unique case (state_q)
      FR_IDLE: in_ready_o = win_i.valid;
      FR_DIV:  ;
      FR_PUSH: begin
        push_o     = !full_i;
        in_ready_o = !full_i && win_i.valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // restoring division by ms/day, DIV_STEPS quotient bits per cycle
  always_comb begin
    rem_d = rem_q;
    lo_d  = lo_q;
    quo_d = quo_q;
    trial = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {rem_d, lo_d[DAYS_W-1]};
      lo_d  = lo_d << 1;
      if (trial >= {1'b0, MS_PER_DAY}) begin
        rem_d = REM_W'(trial - {1'b0, MS_PER_DAY});
        quo_d = {quo_d[DAYS_W-2:0], 1'b1};
      end else begin
        rem_d = trial[REM_W-1:0];
        quo_d = {quo_d[DAYS_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cnt_q    <= '0;
      amount_q <= in_amount_i;
      last_q   <= in_last_i;
      // negative timestamps count as day zero
      if (in_ts_i[TS_W-1]) begin
        rem_q <= '0;
        lo_q  <= '0;
      end else begin
        rem_q <= REM_W'(in_ts_i[TS_W-2:DAYS_W]);
        lo_q  <= in_ts_i[DAYS_W-1:0];
      end
      quo_q <= '0;
    end else if (state_q == FR_DIV) begin
      cnt_q <= cnt_q + 1'b1;
      rem_q <= rem_d;
      lo_q  <= lo_d;
      quo_q <= quo_d;
    end
  end

  assign match = win_i.ok && (WIN_W'(quo_q) >= win_i.lo) && (WIN_W'(quo_q) < win_i.hi);

  assign push_data_o.last   = last_q;
  assign push_data_o.match  = match;
  assign push_data_o.amount = amount_q;

  `MFS_ASSERT(a_accept_win_valid, !accept || win_i.valid, "record taken with stale window")
  `MFS_ASSERT_NEXT(a_div_to_push, (state_q == FR_DIV) && div_done, state_q == FR_PUSH,
                   "division did not end in push")

endmodule

>>> rtl/core/mfs_back.sv
// Back end: accumulates matching amounts and emits the saturated total
// on the last record of a run. Depends on mfs_pkg.
`timescale 1ns / 1ps
`include "month_filtered_sum_unit_defines.svh"

module mfs_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  empty_i,
  input  mfs_pkg::q_entry_t                     pop_data_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [mfs_pkg::OUT_DATA_W-1:0] out_total_o
);
  import mfs_pkg::*;

  logic [TOTAL_W-1:0]    total_q;
  logic [TOTAL_W-1:0]    sum;
  logic [OUT_DATA_W-1:0] sat;
  logic                  fits;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_q;

  // take an entry when the output register is free or being drained
  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    sum  = total_q + (pop_data_i.match ?
           {{(TOTAL_W-AMOUNT_W){pop_data_i.amount[AMOUNT_W-1]}}, pop_data_i.amount} : '0);
    fits = (&sum[TOTAL_W-1:OUT_DATA_W-1]) || !(|sum[TOTAL_W-1:OUT_DATA_W-1]);
    if (fits) begin
      sat = sum[OUT_DATA_W-1:0];
    end else begin
      sat = sum[TOTAL_W-1] ? SAT_MIN : SAT_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        if (pop_data_i.last) begin
          total_q     <= '0;
          out_valid_q <= 1'b1;
        end else begin
          total_q <= sum;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && pop_data_i.last) begin
      out_q <= sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_total_o = out_q;

  `MFS_ASSERT_NEXT(a_last_emits, pop_o && pop_data_i.last, out_valid_q,
                   "last record did not load a result")
  `MFS_ASSERT_NEXT(a_last_clears, pop_o && pop_data_i.last, total_q == '0,
                   "running total not cleared after last record")

endmodule

>>> rtl/core/month_filtered_sum_unit.sv
// Top level of the month-filtered sum unit.
// Depends on mfs_pkg, mfs_window, mfs_front, mfs_fifo and mfs_back.
`timescale 1ns / 1ps

// Sums the amounts of a record stream that fall in one calendar month.
// Each input beat carries a millisecond UTC timestamp, a signed 32-bit
// amount and tlast. The timestamp is turned into whole days (negative
// timestamps count as 1970-01-01), and the record matches when that day
// lies inside the target month selected by the target_year and
// target_month registers (years before 1970 and months 12-15 never match).
// Matching amounts go into a 64-bit running total; on the tlast beat the
// total, that record included, is saturated to signed 32 bits and sent as
// one output beat, then cleared. The front end takes a record only once
// the last is divided, at 3 quotient bits per cycle, and classified. The
// back end accumulates one record per cycle while its output register is
// free or draining; a 4-deep queue sits between them, so a stalled output
// only stops intake once the queue fills. Reset and every configuration
// write hold off input while the day range is recomputed. The user writes
// configuration only while the unit is idle; the unit does not enforce it.
module month_filtered_sum_unit #(
  parameter int unsigned QueueDepth = mfs_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // records in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mfs_pkg::IN_DATA_W-1:0]       s_axis_tdata,   // timestamp_ms[47:0], amount[79:48]
  input  logic                                s_axis_tlast,   // last_record
  // totals out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mfs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // month_total[31:0]
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [mfs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mfs_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import mfs_pkg::*;

  win_t                        win;
  q_entry_t                    push_data, pop_data;
  logic                        push, pop, full, empty;
  logic signed [TS_W-1:0]      in_ts;
  logic signed [AMOUNT_W-1:0]  in_amount;
  logic signed [OUT_DATA_W-1:0] out_total;

  assign in_ts     = s_axis_tdata[TS_W-1:0];
  assign in_amount = s_axis_tdata[TS_W +: AMOUNT_W];

  mfs_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .win_o       (win)
  );

  mfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_ts_i     (in_ts),
    .in_amount_i (in_amount),
    .in_last_i   (s_axis_tlast),
    .win_i       (win),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  mfs_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  mfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_total_o (out_total)
  );

  assign m_axis_tdata = out_total;

endmodule

>>> bench/month_filtered_sum_unit_tb.sv
// Self-checking bench for month_filtered_sum_unit: directed table, then random record runs.
// Depends on mfs_pkg and the month_filtered_sum_unit RTL; needs no other files.
`timescale 1ns / 1ps

module month_filtered_sum_unit_tb;
  import mfs_pkg::*;

  // Bench constants
  localparam longint unsigned DAY_MS     = 64'd86400000;
  localparam longint unsigned DAYS_400Y  = 64'd146097;
  localparam int unsigned     EPOCH_YEAR = 1970;
  localparam int unsigned     LAST_YEAR  = 6430;   // past the largest positive timestamp
  localparam logic [TS_W-1:0] TS_MAX     = 48'h7FFF_FFFF_FFFF;
  localparam logic [TS_W-1:0] TS_MIN     = 48'h8000_0000_0000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd2;  // first index with no register
  localparam int unsigned DRAIN_CYCLES  = 64;       // pipe plus queue, with margin
  localparam int unsigned PHASE_RECORDS = 120;      // 12 phases, ~1450 records
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef enum logic {ROW_RECORD, ROW_CONFIG} row_kind_e;

  // One line of the directed table: a record beat or a register write
  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  wdata;
    logic [TS_W-1:0]        ts;
    logic [AMOUNT_W-1:0]    amount;
    logic                   last;
    logic                   typed;         // expected total written in the row
    logic [OUT_DATA_W-1:0]  typed_total;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  month_filtered_sum_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // timestamp_ms[47:0], amount[79:48]
    .s_axis_tlast  (s_axis_tlast),   // last_record
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // month_total[31:0]
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Shadow of the unit: target registers and the running month sum
  logic [15:0]           tgt_year;
  logic [3:0]            tgt_month;
  longint                month_sum;
  logic [OUT_DATA_W-1:0] month_totals_q[$];   // totals still owed by the unit

  // Typed expectation for the directed row on the input bus
  logic                  typed_valid;
  logic [OUT_DATA_W-1:0] typed_total;

  // Traffic shaping, shared by sender and receiver
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  bit          hold_req;
  int unsigned hold_len;

  // Window of the current target month, used only to aim random timestamps
  bit              win_ok;
  longint unsigned win_first_day;
  longint unsigned win_days;

  int unsigned mismatch_count;
  stim_row_t   directed_rows[$];

  // ---------------------------------------------------------------------------
  // Calendar arithmetic of the predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input bit leap);
    int unsigned n;
    case (m)
      1:             n = leap ? 29 : 28;
      3, 5, 8, 10:   n = 30;
      default:       n = 31;
    endcase
    return n;
  endfunction

  // Timestamp to Gregorian year and month 0-11; negative stamps sit on day 0
  function automatic void civil_year_month(input logic [TS_W-1:0] ts,
                                           output int unsigned yr, output int unsigned mo);
    longint unsigned days;
    int unsigned     per;
    days = 0;
    if (!ts[TS_W-1]) begin
      days = ts;
      days = days / DAY_MS;
    end
    yr   = EPOCH_YEAR + int'(days / DAYS_400Y) * 400;
    days = days % DAYS_400Y;
    forever begin
      per = is_leap_year(yr) ? 366 : 365;
      if (days < per) break;
      days -= per;
      yr++;
    end
    mo = 0;
    while (mo < 11) begin
      per = month_length(mo, is_leap_year(yr));
      if (days < per) break;
      days -= per;
      mo++;
    end
  endfunction

  // Folds one accepted record into the month sum; returns 1 when a total is due
  function automatic logic fold_record(input logic [TS_W-1:0] ts,
                                       input logic [AMOUNT_W-1:0] amt, input logic last,
                                       output logic [OUT_DATA_W-1:0] total);
    int unsigned yr, mo;
    civil_year_month(ts, yr, mo);
    if (yr == tgt_year && mo == tgt_month) month_sum += longint'($signed(amt));
    total = '0;
    if (!last) return 1'b0;
    if (month_sum > 64'sd2147483647)       total = SAT_MAX;
    else if (month_sum < -64'sd2147483648) total = SAT_MIN;
    else                                   total = month_sum[31:0];
    month_sum = 0;
    return 1'b1;
  endfunction

  // First day of a month, counted from 1970-01-01 (stimulus aiming only)
  function automatic longint unsigned first_day_of_month(input int unsigned y,
                                                         input int unsigned m);
    longint unsigned d;
    int unsigned     yy, k, spans;
    spans = (y - EPOCH_YEAR) / 400;
    d  = spans;
    d  = d * DAYS_400Y;
    yy = EPOCH_YEAR + spans * 400;
    while (yy < y) begin
      d += is_leap_year(yy) ? 366 : 365;
      yy++;
    end
    for (k = 0; k < m; k++) d += month_length(k, is_leap_year(y));
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Random field values
  // ---------------------------------------------------------------------------
  function automatic logic [TS_W-1:0] pick_timestamp();
    longint unsigned day, ms;
    int unsigned     sel;
    logic [63:0]     raw;
    sel = $urandom_range(99);
    raw = {$urandom, $urandom};
    if (win_ok && sel < 70) begin
      if (sel < 55) begin
        // inside the target month, any millisecond of the day
        day = win_first_day + $urandom_range(int'(win_days) - 1);
        ms  = day * DAY_MS + $urandom_range(int'(DAY_MS) - 1);
      end else begin
        // a day either side of the month, first or last millisecond
        day = ($urandom_range(1) || win_first_day == 0) ? win_first_day + win_days
                                                         : win_first_day - 1;
        ms  = day * DAY_MS + ($urandom_range(1) ? 0 : DAY_MS - 1);
      end
      if (ms <= TS_MAX) return ms[TS_W-1:0];
      return raw[TS_W-1:0];
    end
    if (sel < 85) return raw[TS_W-1:0];
    if (sel < 93) return -$urandom_range(200_000_000);            // just before the epoch
    ms = $urandom_range(60 * int'(DAY_MS / 1000));                // early 1970, in seconds
    return ms * 1000 + $urandom_range(999);
  endfunction

  function automatic logic [AMOUNT_W-1:0] pick_amount();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return $urandom;
    if (sel < 80) return $urandom_range(200_000) - 100_000;
    return $urandom_range(1) ? SAT_MAX : SAT_MIN;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, receiver and monitors
  // ---------------------------------------------------------------------------
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: random back-pressure, or one long hold-off when asked
  initial begin : sink
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (hold_len - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Every accepted record beat goes through the predictor
  always @(posedge clk_i) begin
    logic [OUT_DATA_W-1:0] total;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (fold_record(s_axis_tdata[TS_W-1:0], s_axis_tdata[TS_W +: AMOUNT_W],
                      s_axis_tlast, total))
        month_totals_q.push_back(typed_valid ? typed_total : total);
    end
  end

  // Every accepted total beat is checked against the oldest one owed
  always @(posedge clk_i) begin
    logic [OUT_DATA_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (month_totals_q.size() == 0) begin
        $error("month_total: expected none, actual %0d", $signed(m_axis_tdata));
        mismatch_count++;
      end else begin
        want = month_totals_q.pop_front();
        if (m_axis_tdata !== want) begin
          $error("month_total: expected %0d, actual %0d", $signed(want),
                 $signed(m_axis_tdata));
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offers one record beat, after random idle cycles, and returns on acceptance
  task automatic send_record(input logic [TS_W-1:0] ts, input logic [AMOUNT_W-1:0] amt,
                             input logic last, input logic typed,
                             input logic [OUT_DATA_W-1:0] total);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    typed_valid = typed;
    typed_total = total;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {amt, ts};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering, waits for every owed total, then lets the pipe empty
  task automatic wait_until_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (month_totals_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] wdata);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= wdata;
    @(posedge clk_i);
    if (idx == CFG_TARGET_YEAR)       tgt_year  = wdata;
    else if (idx == CFG_TARGET_MONTH) tgt_month = wdata[3:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_record(input logic [TS_W-1:0] ts, input logic [AMOUNT_W-1:0] amt,
                            input logic last, input logic typed,
                            input logic [OUT_DATA_W-1:0] total);
    stim_row_t r;
    r = '{ROW_RECORD, '0, '0, ts, amt, last, typed, total};
    directed_rows.push_back(r);
  endtask

  task automatic add_config(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] wdata);
    stim_row_t r;
    r = '{ROW_CONFIG, idx, wdata, '0, '0, 1'b0, 1'b0, '0};
    directed_rows.push_back(r);
  endtask

  // New random target for a phase; also aims the timestamp picker at it
  task automatic pick_target();
    int unsigned     yr, mo, sel;
    longint unsigned first_ms;
    sel = $urandom_range(9);
    case (sel)
      0:       yr = 1970;
      1:       yr = 2000;                      // leap century
      2:       yr = 2100;                      // common century
      3:       yr = LAST_YEAR - 1;             // near the timestamp ceiling
      4:       yr = $urandom_range(65535);
      default: yr = $urandom_range(LAST_YEAR, EPOCH_YEAR);
    endcase
    mo = ($urandom_range(99) < 85) ? $urandom_range(11) : $urandom_range(15, 12);
    if ($urandom_range(1)) begin
      write_config(CFG_TARGET_YEAR, yr);
      write_config(CFG_TARGET_MONTH, {$urandom_range(4095), mo[3:0]});
    end else begin
      write_config(CFG_TARGET_MONTH, {$urandom_range(4095), mo[3:0]});
      write_config(CFG_TARGET_YEAR, yr);
    end
    if ($urandom_range(2) == 0) write_config($urandom_range(255, CFG_UNUSED), $urandom);
    win_ok = (yr >= EPOCH_YEAR) && (yr < LAST_YEAR) && (mo < 12);
    if (win_ok) begin
      win_first_day = first_day_of_month(yr, mo);
      win_days      = month_length(mo, is_leap_year(yr));
      first_ms      = win_first_day * DAY_MS;
      win_ok        = (first_ms <= TS_MAX);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t   r;
    int unsigned mode, ph, sent, run_len, k;
    bit          paused;

    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    tgt_year       = YEAR_RESET;
    tgt_month      = MONTH_RESET;
    month_sum      = 0;
    typed_valid    = 1'b0;
    typed_total    = '0;
    hold_req       = 1'b0;
    hold_len       = HOLD_CYCLES;
    win_ok         = 1'b0;
    win_first_day  = 0;
    win_days       = 0;
    mismatch_count = 0;
    src_idle_pct   = 24;
    sink_idle_pct  = 49;

    // Directed table. Reset target is January 1970.
    add_record(48'd0, 32'd100, 1'b1, 1'b1, 32'd100);
    add_record('1, -32'sd5, 1'b1, 1'b1, -32'sd5);            // negative stamp -> Jan 1970
    add_record(TS_MIN, 32'd7, 1'b0, 1'b0, '0);
    add_record(48'd86399999, 32'd3, 1'b0, 1'b0, '0);         // last ms of day 0
    add_record(48'd2678400000, 32'd1000, 1'b1, 1'b1, 32'd10); // Feb 1 1970, no match
    add_record(48'd0, SAT_MAX, 1'b0, 1'b0, '0);
    add_record(48'd2678399999, SAT_MAX, 1'b1, 1'b1, SAT_MAX); // clips high
    add_record(48'd0, SAT_MIN, 1'b0, 1'b0, '0);
    add_record(48'd0, SAT_MIN, 1'b1, 1'b1, SAT_MIN);          // clips low
    add_record(TS_MAX, 32'd9, 1'b1, 1'b1, 32'd0);
    add_config(CFG_TARGET_YEAR, 16'd2000);
    add_config(CFG_TARGET_MONTH, 16'hFFF1);                   // upper bits dropped: Feb
    add_record(48'd951782400000, 32'd55, 1'b0, 1'b0, '0);     // Feb 29 2000
    add_record(48'd951868800000, 32'd44, 1'b1, 1'b0, '0);     // Mar 1 2000
    add_config(CFG_UNUSED, 16'hFFFF);                         // no register there
    add_record(48'd951782400000, -32'sd3, 1'b1, 1'b0, '0);
    add_config(CFG_TARGET_MONTH, 16'd15);                     // never matches
    add_record(48'd975628800000, 32'd1, 1'b1, 1'b0, '0);
    add_config(CFG_TARGET_YEAR, 16'hFFFF);
    add_config(CFG_TARGET_MONTH, 16'd11);
    add_record(TS_MAX, 32'hFFFF_FFFF, 1'b1, 1'b0, '0);
    add_config(CFG_TARGET_YEAR, 16'd0);
    add_config(CFG_TARGET_MONTH, 16'd0);
    add_record(48'd0, 32'd77, 1'b1, 1'b1, 32'd0);             // year 0 never reached
    add_config(CFG_TARGET_YEAR, 16'd1969);
    add_config(CFG_TARGET_MONTH, 16'd11);
    add_record('1, 32'd5, 1'b1, 1'b0, '0);
    add_config(CFG_TARGET_YEAR, 16'd2100);
    add_config(CFG_TARGET_MONTH, 16'd2);
    add_record(48'd4107456000000, 32'd12, 1'b0, 1'b0, '0);    // Feb 28 2100
    add_record(48'd4107542400000, 32'd77, 1'b1, 1'b0, '0);    // Mar 1 2100, no Feb 29

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.kind == ROW_CONFIG) begin
        if (i == 0 || directed_rows[i-1].kind != ROW_CONFIG) wait_until_drained();
        write_config(r.idx, r.wdata);
      end else begin
        send_record(r.ts, r.amount, r.last, r.typed, r.typed_total);
      end
    end

    // Random runs: three traffic shapes, four targets each
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin src_idle_pct = 24; sink_idle_pct = 49; end
        1:       begin src_idle_pct = 49; sink_idle_pct = 24; end
        default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
      endcase
      for (ph = 0; ph < 4; ph++) begin
        wait_until_drained();
        pick_target();
        // long output stall while records keep coming: queue fills, input stalls
        if (mode == 0 && ph == 1) hold_req = 1'b1;
        sent   = 0;
        paused = 0;
        while (sent < PHASE_RECORDS) begin
          k = $urandom_range(99);
          run_len = (k < 10) ? 1 : (k < 80) ? $urandom_range(12, 2) : $urandom_range(40, 13);
          for (k = 1; k <= run_len; k++) begin
            send_record(pick_timestamp(), pick_amount(), k == run_len, 1'b0, '0);
            sent++;
          end
          // sender pause mid-phase until every owed total is back
          if (ph == 2 && !paused && sent >= PHASE_RECORDS / 2) begin
            paused = 1;
            wait_until_drained();
          end
        end
      end
    end

    wait_until_drained();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
